[hw/rtl/lkvc_pkg.sv]
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // rank update applied at the end of an item
  localparam logic [1:0] UPD_NONE   = 2'd0;
  localparam logic [1:0] UPD_TOUCH  = 2'd1;
  localparam logic [1:0] UPD_INSERT = 2'd2;
  localparam logic [1:0] UPD_EVICT  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       update;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic has_room;
    logic is_write;
  } status_t;

endpackage

[hw/rtl/lkvc_if.sv]
// request and response channel interfaces
interface lkvc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lkvc_pkg::KEY_W-1:0]   key;
  logic [lkvc_pkg::VALUE_W-1:0] write_value;

  modport source (output valid, output op, output key, output write_value, input ready);
  modport sink   (input valid, input op, input key, input write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lkvc_pkg::VALUE_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

[hw/rtl/lkvc_ctrl.sv]
// control state machine: request intake, scan sequencing, update and result beat
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  lkvc_pkg::status_t st,
  output lkvc_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] kind;

  // what the end of the item does to the order
  always_comb begin
    if (st.found) begin
      kind = lkvc_pkg::UPD_TOUCH;
    end else if (!st.is_write) begin
      kind = lkvc_pkg::UPD_NONE;
    end else if (st.has_room) begin
      kind = lkvc_pkg::UPD_INSERT;
    end else begin
      kind = lkvc_pkg::UPD_EVICT;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.kind   = kind;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        // wait until the result register is free
        if (!rsp_valid || rsp_ready) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/lkvc_dp.sv]
// datapath: key/value memories, entry scan, age ranks and result register
module lkvc_dp #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                         req_op,
  input  logic [lkvc_pkg::KEY_W-1:0]   req_key,
  input  logic [lkvc_pkg::VALUE_W-1:0] req_write_value,
  output logic                         rsp_hit,
  output logic [lkvc_pkg::VALUE_W-1:0] rsp_read_value,
  input  lkvc_pkg::cmd_t               cmd,
  output lkvc_pkg::status_t            st
);

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  logic [lkvc_pkg::KEY_W-1:0]   key_mem [ENTRIES];
  logic [lkvc_pkg::VALUE_W-1:0] val_mem [ENTRIES];

  logic [lkvc_pkg::CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]             occupancy;
  logic [CNT_W-1:0]             occupancy_next;
  logic                         valid      [ENTRIES];
  logic                         valid_next [ENTRIES];
  logic [IW-1:0]                rank       [ENTRIES];
  logic [IW-1:0]                rank_next  [ENTRIES];

  logic                         op_q;
  logic [lkvc_pkg::KEY_W-1:0]   key_req;
  logic [lkvc_pkg::VALUE_W-1:0] val_req;

  logic [CNT_W-1:0]             cnt;
  logic                         rd_vld;
  logic [IW-1:0]                rd_idx;
  logic [lkvc_pkg::KEY_W-1:0]   key_q;
  logic [lkvc_pkg::VALUE_W-1:0] val_q;

  logic                         found;
  logic [IW-1:0]                hit_idx;
  logic [IW-1:0]                hit_rank;
  logic [lkvc_pkg::VALUE_W-1:0] hit_val;
  logic                         old_found;
  logic [IW-1:0]                old_idx;
  logic [IW-1:0]                old_rank;
  logic                         free_found;
  logic [IW-1:0]                free_idx;

  logic [CW-1:0]                cap_ext;
  logic [CW-1:0]                eff_cap;
  logic [IW-1:0]                slot;
  logic [IW-1:0]                t_idx;
  logic [IW-1:0]                t_rank;
  logic                         cur_valid;
  logic [IW-1:0]                cur_rank;
  logic                         mem_we;

  assign cap_ext = CW'(capacity);

  // zero counts as one, anything above the entry count saturates
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign st.scan_done = (cnt == CNT_W'(ENTRIES)) && !rd_vld;
  assign st.found     = found;
  assign st.has_room  = CW'(occupancy) < eff_cap;
  assign st.is_write  = (op_q == lkvc_pkg::OP_WRITE);

  assign cur_valid = valid[rd_idx];
  assign cur_rank  = rank[rd_idx];

  always_comb begin
    if (found) begin
      slot = hit_idx;
    end else if (cmd.kind == lkvc_pkg::UPD_INSERT) begin
      slot = free_idx;
    end else if (old_found) begin
      slot = old_idx;
    end else begin
      slot = '0;
    end
  end

  assign t_idx  = (cmd.kind == lkvc_pkg::UPD_TOUCH) ? hit_idx : old_idx;
  assign t_rank = (cmd.kind == lkvc_pkg::UPD_TOUCH) ? hit_rank : old_rank;
  assign mem_we = cmd.update && (op_q == lkvc_pkg::OP_WRITE);

  // order update for all lanes in parallel
  always_comb begin
    occupancy_next = occupancy;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_next[i] = valid[i];
      rank_next[i]  = rank[i];
    end
    case (cmd.kind)
      lkvc_pkg::UPD_TOUCH: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && IW'(i) != t_idx && rank[i] < t_rank) begin
            rank_next[i] = rank[i] + IW'(1);
          end
        end
        rank_next[t_idx] = '0;
      end
      lkvc_pkg::UPD_INSERT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i]) begin
            rank_next[i] = rank[i] + IW'(1);
          end
        end
        valid_next[free_idx] = 1'b1;
        rank_next[free_idx]  = '0;
        occupancy_next       = occupancy + CNT_W'(1);
      end
      lkvc_pkg::UPD_EVICT: begin
        if (old_found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && IW'(i) != t_idx && rank[i] < t_rank) begin
              rank_next[i] = rank[i] + IW'(1);
            end
          end
          rank_next[t_idx] = '0;
        end else begin
          // nothing valid to evict: take the first slot
          valid_next[0]  = 1'b1;
          rank_next[0]   = '0;
          occupancy_next = CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[slot] <= key_req;
      val_mem[slot] <= val_req;
    end
    if (cmd.scan && cnt < CNT_W'(ENTRIES)) begin
      key_q <= key_mem[cnt[IW-1:0]];
      val_q <= val_mem[cnt[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= lkvc_pkg::CAP_RESET;
      occupancy <= '0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.load) begin
        cnt    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.scan) begin
        if (cnt < CNT_W'(ENTRIES)) begin
          cnt    <= cnt + CNT_W'(1);
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
      end
      if (cmd.update) begin
        occupancy <= occupancy_next;
        for (int i = 0; i < ENTRIES; i++) begin
          valid[i] <= valid_next[i];
          rank[i]  <= rank_next[i];
        end
      end
    end
  end

  // request capture, scan tracking and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= req_op;
      key_req    <= req_key;
      val_req    <= req_write_value;
      found      <= 1'b0;
      old_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan && rd_vld) begin
      if (cur_valid && key_q == key_req && !found) begin
        found    <= 1'b1;
        hit_idx  <= rd_idx;
        hit_rank <= cur_rank;
        hit_val  <= val_q;
      end
      if (cur_valid && (!old_found || cur_rank > old_rank)) begin
        old_found <= 1'b1;
        old_idx   <= rd_idx;
        old_rank  <= cur_rank;
      end
      if (!cur_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    if (cmd.scan && cnt < CNT_W'(ENTRIES)) begin
      rd_idx <= cnt[IW-1:0];
    end
    if (cmd.update) begin
      rsp_hit <= found;
      rsp_read_value <= (found && op_q == lkvc_pkg::OP_LOOKUP) ? hit_val : '0;
    end
  end

endmodule

[hw/rtl/lru_key_value_cache.sv]
// lru key-value cache: one request in flight, entries scanned one per cycle
// the next request is taken only once the previous request's scan and rank update finish
// a new request is taken while the previous result beat still waits
// reset clears valid bits, ranks, occupancy and control; capacity returns to 8
// key and value memories are not cleared
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
  lkvc_req_if.sink                   req,
  lkvc_rsp_if.source                 rsp
);

  lkvc_pkg::cmd_t    cmd;
  lkvc_pkg::status_t st;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .req_op          (req.op),
    .req_key         (req.key),
    .req_write_value (req.write_value),
    .rsp_hit         (rsp.hit),
    .rsp_read_value  (rsp.read_value),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

[tb/lru_key_value_cache_test.sv]
// self-checking testbench for the lru key-value cache, directed table then random phases
`timescale 1ns / 1ps

module lru_key_value_cache_test;
  import lkvc_pkg::*;

  localparam int ENTRIES      = ENTRIES_DEF;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_DIRECTED = 29;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;   // capacity on a config row
    logic               typed;
    logic               exp_hit;
    logic [VALUE_W-1:0] exp_value;
  } dir_row_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } cache_rsp_t;

  // typed rows hold results that follow directly from the empty cache
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, OP_WRITE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0000, 32'h5A5A_A5A5, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_A5A5},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0001, 32'h1111_1111, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0002, 32'h2222_2222, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0003, 32'h3333_3333, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0004, 32'h4444_4444, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0005, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0006, 32'h6666_6666, 1'b0, 1'b0, 32'h0000_0000},
    // cache full: this one evicts the oldest key
    '{ROW_ITEM, OP_WRITE,  32'h0000_0007, 32'h7777_7777, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // capacity below occupancy: replace in place
    '{ROW_CFG,  OP_LOOKUP, 32'h0000_0000, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0100, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // zero capacity acts as one
    '{ROW_CFG,  OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0200, 32'hCAFE_F00D, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0200, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // capacity above the entry count saturates
    '{ROW_CFG,  OP_LOOKUP, 32'h0000_0000, 32'h0000_000F, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0300, 32'h0BAD_F00D, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_WRITE,  32'h0000_0301, 32'h8000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0300, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  OP_LOOKUP, 32'h0000_0000, 32'h0000_0008, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, OP_LOOKUP, 32'h0000_0100, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] = '{
    CAP_W'(1), CAP_W'(8), CAP_W'(3), CAP_W'(15), CAP_W'(0), CAP_W'(5), CAP_W'(2), CAP_W'(8)
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // shadow copy of the cache contents
  logic [KEY_W-1:0]   shadow_key   [ENTRIES];
  logic [VALUE_W-1:0] shadow_value [ENTRIES];
  bit                 shadow_valid [ENTRIES];
  int unsigned        shadow_rank  [ENTRIES];
  int unsigned        shadow_occupancy;
  logic [CAP_W-1:0]   shadow_cap;

  cache_rsp_t  expected_rsp_q [$];
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned cap_writes;
  bit          calm;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // no random idling on either side through this window
  assign calm = (cycle_count >= 6000) && (cycle_count < 9000);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_rsp_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // make idx the most recent; younger valid entries age by one
  function automatic void promote_entry(int idx);
    int unsigned r;
    r = shadow_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && i != idx && shadow_rank[i] < r) shadow_rank[i]++;
    shadow_rank[idx] = 0;
  endfunction

  function automatic cache_rsp_t cache_access(logic op, logic [KEY_W-1:0] key,
                                              logic [VALUE_W-1:0] value);
    cache_rsp_t  res;
    int          idx;
    int          slot;
    int unsigned eff;
    idx = -1;
    slot = -1;
    eff = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
    for (int i = 0; i < ENTRIES; i++)
      if (idx < 0 && shadow_valid[i] && shadow_key[i] == key) idx = i;
    res.hit = (idx >= 0);
    res.read_value = '0;
    if (op == OP_LOOKUP) begin
      if (idx >= 0) begin
        res.read_value = shadow_value[idx];
        promote_entry(idx);
      end
    end else if (idx >= 0) begin
      shadow_value[idx] = value;
      promote_entry(idx);
    end else begin
      if (shadow_occupancy < eff)
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot] = 0;
        shadow_occupancy++;
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && (slot < 0 || shadow_rank[i] > shadow_rank[slot])) slot = i;
        if (slot < 0) begin
          slot = 0;
          shadow_valid[0] = 1'b1;
          shadow_rank[0] = 0;
          shadow_occupancy = 1;
        end else begin
          promote_entry(slot);
        end
      end
      shadow_key[slot] = key;
      shadow_value[slot] = value;
    end
    return res;
  endfunction

  task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                              bit typed, cache_rsp_t typed_rsp);
    cache_rsp_t predicted;
    while (!calm && $urandom_range(0, 99) < 8) begin
      req_ch.valid <= 1'b0;
      req_ch.key   <= $urandom;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.key         <= key;
    req_ch.write_value <= value;
    do @(posedge clk); while (!req_ch.ready);
    predicted = cache_access(op, key, value);
    expected_rsp_q.push_back(typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  // only written with the cache drained
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap = cap;
    cap_writes++;
  endtask

  // result side: checks every beat, idles at random, one long hold-off
  initial begin : result_sink
    int         hold_left;
    bit         held;
    cache_rsp_t got;
    cache_rsp_t want;
    hold_left = 0;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.hit = rsp_ch.hit;
        got.read_value = rsp_ch.read_value;
        results_seen++;
        if (got.hit) hits_seen++;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: hit=%0b value=%h", got.hit, got.read_value);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                       results_seen, want.hit, want.read_value, got.hit, got.read_value);
          end
        end
      end
      if (!held && results_seen == HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= rst ? 1'b0 : (calm || $urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [12];
    int unsigned      pool_size;
    int unsigned      eff;
    int unsigned      pick;
    logic             op;
    logic [KEY_W-1:0] key;
    cache_rsp_t       typed_rsp;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_LOOKUP;
    req_ch.key = '0;
    req_ch.write_value = '0;
    cycle_count = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    cap_writes = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_occupancy = 0;
    shadow_cap = CAP_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_capacity(DIRECTED[r].value[CAP_W-1:0]);
      end else begin
        typed_rsp.hit = DIRECTED[r].exp_hit;
        typed_rsp.read_value = DIRECTED[r].exp_value;
        send_request(DIRECTED[r].op, DIRECTED[r].key, DIRECTED[r].value,
                     DIRECTED[r].typed, typed_rsp);
      end
    end

    typed_rsp = '0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(PHASE_CAPS[p]);
      eff = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // fresh key pool now and then, slightly larger than the capacity
        if (n % 50 == 0) begin
          pool_size = eff + $urandom_range(1, 3);
          for (int i = 0; i < 12; i++) key_pool[i] = $urandom;
          if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
          if ($urandom_range(0, 3) == 0) key_pool[1] = '1;
        end
        pick = $urandom_range(0, 99);
        op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_LOOKUP;
        if (pick < 12) key = $urandom;
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        send_request(op, key, $urandom, 1'b0, typed_rsp);
      end
    end

    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d hits, %0d capacity writes",
             items_sent, results_seen, hits_seen, cap_writes);
    $display("%0d phases over capacities 0 to 15, one long response hold-off, %0d mismatches",
             NUM_PHASES, mismatches);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
